>>> rtl/core/rrp_pkg.sv
package rrp_pkg;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
    localparam int unsigned ENTRY_W     = 64;

    localparam logic [7:0] T_NONE         = 8'd0;
    localparam logic [7:0] T_ABS32        = 8'd1;
    localparam logic [7:0] T_BRANCH       = 8'd16;
    localparam logic [7:0] T_JAL          = 8'd17;
    localparam logic [7:0] T_CALL         = 8'd18;
    localparam logic [7:0] T_CALL_PLT     = 8'd19;
    localparam logic [7:0] T_PCREL_HI20   = 8'd23;
    localparam logic [7:0] T_PCREL_LO12_I = 8'd24;
    localparam logic [7:0] T_PCREL_LO12_S = 8'd25;
    localparam logic [7:0] T_HI20         = 8'd26;
    localparam logic [7:0] T_LO12_I       = 8'd27;
    localparam logic [7:0] T_LO12_S       = 8'd28;
    localparam logic [7:0] T_RELAX        = 8'd51;
    localparam logic [7:0] T_ALIGN        = 8'd52;

    typedef struct packed {
        logic load;
        logic calc_val;
        logic calc_pc;
        logic scan_start;
        logic scan_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_lo;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/rrp_ram.sv
module rrp_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/rrp_ctrl.sv
module rrp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rrp_pkg::t_sts i_sts,
    output rrp_pkg::t_cmd o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_VAL, S_PC, S_SCAN, S_FIN} t_state;
    t_state r_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_valid;
        o_cmd.calc_val   = (r_state == S_VAL);
        o_cmd.calc_pc    = (r_state == S_PC);
        o_cmd.scan_start = (r_state == S_PC) && i_sts.is_lo;
        o_cmd.scan_step  = (r_state == S_SCAN);
        o_cmd.finish     = (r_state == S_FIN) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) r_state <= S_VAL;
                S_VAL:  r_state <= S_PC;
                S_PC:   r_state <= i_sts.is_lo ? S_SCAN : S_FIN;
                S_SCAN: if (i_sts.scan_done) r_state <= S_FIN;
                S_FIN:  if (i_sts.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/core/rrp_dpath.sv
module rrp_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rrp_pkg::t_cmd i_cmd,
    output rrp_pkg::t_sts o_sts,
    input  logic [7:0]    i_type,
    input  logic [31:0]   i_addr,
    input  logic [31:0]   i_sym,
    input  logic [31:0]   i_add,
    input  logic [31:0]   i_w0,
    input  logic [31:0]   i_w1,
    input  logic          i_take,
    output logic          o_valid,
    output logic [31:0]   o_w0,
    output logic [31:0]   o_w1,
    output logic          o_we0,
    output logic          o_we1,
    output logic          o_status
);
    localparam int unsigned IW = rrp_pkg::IDX_W;

    function automatic logic [31:0] put_hi20(input logic [31:0] w, input logic [31:0] v);
        logic [31:0] s;
        s = v + 32'h800;
        return {s[31:12], w[11:0]};
    endfunction

    function automatic logic [31:0] put_lo12_i(input logic [31:0] w, input logic [31:0] v);
        return {v[11:0], w[19:0]};
    endfunction

    function automatic logic [31:0] put_lo12_s(input logic [31:0] w, input logic [31:0] v);
        return {v[11:5], w[24:12], v[4:0], w[6:0]};
    endfunction

    logic [7:0]  r_type;
    logic [31:0] r_addr, r_sym, r_add, r_w0, r_w1, r_val, r_pc, r_off;
    logic [IW-1:0] r_scan_addr, r_wp;
    logic        r_chk, r_chk_last, r_rd_vld;
    logic        r_valid [rrp_pkg::TABLE_DEPTH];
    logic        r_out_valid, r_we0, r_we1, r_st;
    logic [31:0] r_o0, r_o1;

    logic [rrp_pkg::ENTRY_W-1:0] rdata;
    logic [31:0] ent_addr, ent_off;
    logic        hit, ram_we;
    logic [31:0] n0, n1;
    logic        nwe0, nwe1, nst;

    assign ram_we = i_cmd.finish && (r_type == rrp_pkg::T_PCREL_HI20);

    rrp_ram #(.WIDTH(rrp_pkg::ENTRY_W), .DEPTH(rrp_pkg::TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wp),
        .i_wdata({r_pc, r_addr}),
        .i_raddr(r_scan_addr),
        .o_rdata(rdata)
    );

    // An entry never written reads as address zero with offset zero.
    assign ent_addr = r_rd_vld ? rdata[31:0]  : 32'd0;
    assign ent_off  = r_rd_vld ? rdata[63:32] : 32'd0;
    assign hit      = r_chk && (ent_addr == r_sym);

    assign o_sts.is_lo     = (r_type == rrp_pkg::T_PCREL_LO12_I) ||
                             (r_type == rrp_pkg::T_PCREL_LO12_S);
    assign o_sts.scan_done = hit || (r_chk && r_chk_last);
    assign o_sts.out_free  = !r_out_valid || i_take;

    always_comb begin
        n0 = r_w0; n1 = r_w1; nwe0 = 1'b1; nwe1 = 1'b0; nst = 1'b0;
        case (r_type)
            rrp_pkg::T_NONE, rrp_pkg::T_RELAX, rrp_pkg::T_ALIGN: nwe0 = 1'b0;
            rrp_pkg::T_ABS32:        n0 = r_val;
            rrp_pkg::T_HI20:         n0 = put_hi20(r_w0, r_val);
            rrp_pkg::T_LO12_I:       n0 = put_lo12_i(r_w0, r_val);
            rrp_pkg::T_LO12_S:       n0 = put_lo12_s(r_w0, r_val);
            rrp_pkg::T_PCREL_HI20:   n0 = put_hi20(r_w0, r_pc);
            rrp_pkg::T_PCREL_LO12_I: n0 = put_lo12_i(r_w0, r_off);
            rrp_pkg::T_PCREL_LO12_S: n0 = put_lo12_s(r_w0, r_off);
            rrp_pkg::T_CALL, rrp_pkg::T_CALL_PLT: begin
                n0   = put_hi20(r_w0, r_pc);
                n1   = put_lo12_i(r_w1, r_pc);
                nwe1 = 1'b1;
            end
            rrp_pkg::T_BRANCH:
                n0 = {r_pc[12], r_pc[10:5], r_w0[24:12], r_pc[4:1], r_pc[11], r_w0[6:0]};
            rrp_pkg::T_JAL:
                n0 = {r_pc[20], r_pc[10:1], r_pc[11], r_pc[19:12], r_w0[11:0]};
            default: begin
                nwe0 = 1'b0;
                nst  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_type <= i_type; r_addr <= i_addr; r_sym <= i_sym;
            r_add  <= i_add;  r_w0   <= i_w0;   r_w1  <= i_w1;
        end
        if (i_cmd.calc_val) r_val <= r_sym + r_add;
        if (i_cmd.calc_pc)  r_pc  <= r_val - r_addr;
        if (i_cmd.scan_start) begin
            r_scan_addr <= '0;
            r_off       <= '0;
        end else if (i_cmd.scan_step) begin
            if (hit) r_off <= ent_off;
            if (r_scan_addr != IW'(rrp_pkg::TABLE_DEPTH - 1)) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
        end
        r_rd_vld   <= r_valid[r_scan_addr];
        r_chk_last <= (r_scan_addr == IW'(rrp_pkg::TABLE_DEPTH - 1));
        if (i_cmd.finish) begin
            r_o0 <= n0; r_o1 <= n1; r_we0 <= nwe0; r_we1 <= nwe1; r_st <= nst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk       <= 1'b0;
            r_wp        <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < int'(rrp_pkg::TABLE_DEPTH); i++) r_valid[i] <= 1'b0;
        end else begin
            r_chk <= i_cmd.scan_step && !o_sts.scan_done;
            if (ram_we) begin
                r_valid[r_wp] <= 1'b1;
                r_wp <= (r_wp == IW'(rrp_pkg::TABLE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_cmd.finish)  r_out_valid <= 1'b1;
            else if (i_take)   r_out_valid <= 1'b0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_w0     = r_o0;
    assign o_w1     = r_o1;
    assign o_we0    = r_we0;
    assign o_we1    = r_we1;
    assign o_status = r_st;

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && i_cmd.scan_step)) else $error("table write during scan");
    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_take)) else $error("result overwritten");
    a_hit_needs_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> $past(i_cmd.scan_step)) else $error("compare without read");
    a_unsupported_no_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_st) |-> (!r_we0 && !r_we1)) else $error("write on error");
endmodule

>>> rtl/core/riscv_relocation_patcher.sv
// Channel | Dir | Signals             | Contents (low bit first)
// s       | in  | i_s_tvalid/o_s_tready | tuser: reloc_type; tdata: see port
// m       | out | o_m_tvalid/i_m_tready | tdata: see port
//
// Plain relocations go through the load, value, PC and finish states from request to result.
// PC-relative LO12 adds a scan of the 256-entry site table, one entry per
// cycle through the table RAM read port.
// Reset is synchronous; it empties the site table at once through valid bits.
// The result register decouples the sides; a stalled output holds the
// finished result and delays only the next request's final cycle.
module riscv_relocation_patcher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // patch_address, symbol_value, addend, insn_word0, insn_word1
    input  logic [159:0] i_s_tdata,
    // reloc_type
    input  logic [7:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // patched_word0, patched_word1, write_word0, write_word1, status, zero pad
    output logic [71:0]  o_m_tdata
);
    rrp_pkg::t_cmd cmd;
    rrp_pkg::t_sts sts;
    logic [31:0] w0, w1;
    logic        we0, we1, st;

    rrp_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_tvalid),
        .o_ready(o_s_tready),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    rrp_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_type  (i_s_tuser),
        .i_addr  (i_s_tdata[31:0]),
        .i_sym   (i_s_tdata[63:32]),
        .i_add   (i_s_tdata[95:64]),
        .i_w0    (i_s_tdata[127:96]),
        .i_w1    (i_s_tdata[159:128]),
        .i_take  (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_w0    (w0),
        .o_w1    (w1),
        .o_we0   (we0),
        .o_we1   (we1),
        .o_status(st)
    );

    assign o_m_tdata = {5'd0, st, we1, we0, w1, w0};
endmodule
